// File: hdl/brcc_pkg.sv
// Shared types and constants for the batch reservation conflict checker.
// Used by the front queue, the back engine and the top level.
package brcc_pkg;

    localparam int KEYS_DEF    = 1024;
    localparam int WORKERS_DEF = 64;
    localparam int ACT_W       = 3;
    localparam int KEY_W       = 10;
    localparam int ID_W        = 32;
    localparam int WID_W       = 6;
    localparam int FLAG_W      = 64;

    // Action codes as they arrive on the input channel.
    localparam logic [ACT_W-1:0] ACT_BEGIN = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RAW   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_WAR   = 3'd4;

    // Classified operation carried from the front to the back.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_BADW,
        OP_BEGIN,
        OP_WRITE,
        OP_READ,
        OP_RAW,
        OP_WAR
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  txn_id;
        logic [ID_W-1:0]  batch;
        logic [WID_W-1:0] worker;
    } item_t;

    // Head of the front queue as seen by the back.
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    // Writer record of one key.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [ID_W-1:0]  batch;
        logic [WID_W-1:0] worker;
    } wrec_t;

endpackage

// File: hdl/brcc_front.sv
// Front part: classifies each input transfer and holds it in a two-entry queue.
// Depends on brcc_pkg.
module brcc_front
    import brcc_pkg::*;
#(
    parameter int KEYS    = KEYS_DEF,
    parameter int WORKERS = WORKERS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             busy,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [ACT_W-1:0] action,
    input  logic [KEY_W-1:0] key,
    input  logic [ID_W-1:0]  txn_id,
    input  logic [ID_W-1:0]  batch,
    input  logic [WID_W-1:0] worker,
    output head_t            head,
    input  logic             pop
);

    item_t      q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       do_pop;
    op_t        op;
    logic       key_ok;
    item_t      item;

    // Classify the action against the worker and key ranges.
    always_comb
    begin
        key_ok = (32'(key) < 32'(KEYS));
        op     = OP_NOP;
        if (32'(worker) >= 32'(WORKERS))
        begin
            op = OP_BADW;
        end
        else if (action == ACT_BEGIN)
        begin
            op = OP_BEGIN;
        end
        else if (key_ok)
        begin
            case (action)
                ACT_WRITE: op = OP_WRITE;
                ACT_READ:  op = OP_READ;
                ACT_RAW:   op = OP_RAW;
                ACT_WAR:   op = OP_WAR;
                default:   op = OP_NOP;
            endcase
        end
        item.op     = op;
        item.key    = key;
        item.txn_id = txn_id;
        item.batch  = batch;
        item.worker = worker;
    end

    // Queue control.
    assign in_stall    = busy || (cnt_reg == 2'd2);
    assign push        = in_valid && !in_stall;
    assign do_pop      = pop && (cnt_reg != 2'd0);
    assign wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
    assign cnt_next    = cnt_reg + {1'b0, push} - {1'b0, do_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = q_reg[rd_ptr_reg];

endmodule

// File: hdl/brcc_back.sv
// Back part: per-key record memories, abort flags and the result register.
// Depends on brcc_pkg.
module brcc_back
    import brcc_pkg::*;
#(
    parameter int KEYS    = KEYS_DEF,
    parameter int WORKERS = WORKERS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    output logic busy,
    input  head_t head,
    output logic pop,
    output logic out_valid,
    input  logic out_stall,
    output logic conflict,
    output logic worker_aborted
);

    localparam int KAW    = $clog2(KEYS);
    localparam int WAW    = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int META_W = ID_W + WORKERS;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [KAW-1:0]                  clr_cnt_reg;
    logic [KAW-1:0]                  clr_cnt_next;
    item_t                           cur_reg;
    logic                            out_valid_reg;
    logic                            conflict_reg;
    logic                            aborted_reg;
    logic [WORKERS-1:0]              abort_reg;
    logic [WORKERS-1:0]              abort_next;

    wrec_t                           wr_mem   [KEYS];
    logic [META_W-1:0]               meta_mem [KEYS];
    logic [WORKERS-1:0][ID_W-1:0]    rid_mem  [KEYS];

    wrec_t                           wr_q;
    logic [META_W-1:0]               meta_q;
    logic [WORKERS-1:0][ID_W-1:0]    rid_q;

    logic                            rd_en;
    logic [KAW-1:0]                  rd_addr;
    logic [KAW-1:0]                  wa;
    logic                            out_free;
    logic                            fire;
    logic                            clearing;

    wrec_t                           wr_new;
    logic [META_W-1:0]               meta_new;
    logic [WORKERS-1:0][ID_W-1:0]    rid_new;
    logic                            wr_we;
    logic                            meta_we;
    logic                            rid_we;
    logic                            wr_upd;
    logic                            meta_upd;
    logic                            rid_upd;
    logic [FLAG_W-1:0]               ab64;
    logic [FLAG_W-1:0]               abn64;
    logic [ID_W-1:0]                 rb;
    logic [WORKERS-1:0]              mask;
    logic [WORKERS-1:0]              w_bit;
    logic                            hit;
    logic                            cf;
    logic                            ab_out;

    assign clearing = (state_reg == ST_CLEAR);
    assign busy     = clearing;
    assign out_free = !out_valid_reg || !out_stall;
    assign rd_en    = (state_reg == ST_IDLE) && head.valid;
    assign pop      = rd_en;
    assign rd_addr  = KAW'(head.item.key);
    assign fire     = (state_reg == ST_EXEC) && out_free;

    // Execute one classified item against the records read for its key.
    always_comb
    begin
        ab64     = FLAG_W'(abort_reg);
        abn64    = ab64;
        wr_new   = wr_q;
        meta_new = meta_q;
        rid_new  = rid_q;
        wr_upd   = 1'b0;
        meta_upd = 1'b0;
        rid_upd  = 1'b0;
        cf       = 1'b0;
        hit      = 1'b0;
        rb       = meta_q[META_W-1:WORKERS];
        mask     = meta_q[WORKERS-1:0];
        w_bit    = WORKERS'(FLAG_W'(1) << cur_reg.worker);
        case (cur_reg.op)
            OP_BEGIN:
            begin
                abn64[cur_reg.worker] = 1'b0;
            end
            OP_WRITE:
            begin
                if (wr_q.id < cur_reg.txn_id && wr_q.batch == cur_reg.batch)
                begin
                    abn64[cur_reg.worker] = 1'b1;
                end
                else if (wr_q.id == cur_reg.txn_id && wr_q.batch == cur_reg.batch)
                begin
                    wr_upd = 1'b0;
                end
                else if (wr_q.id > cur_reg.txn_id || wr_q.batch < cur_reg.batch
                         || wr_q.id == '0)
                begin
                    if (wr_q.batch == cur_reg.batch && wr_q.id != '0)
                    begin
                        abn64[wr_q.worker] = 1'b1;
                    end
                    wr_upd        = 1'b1;
                    wr_new.id     = cur_reg.txn_id;
                    wr_new.worker = cur_reg.worker;
                    if (wr_q.batch < cur_reg.batch)
                    begin
                        wr_new.batch = cur_reg.batch;
                    end
                end
            end
            OP_READ:
            begin
                for (int i = 0; i < WORKERS; i++)
                begin
                    if (mask[i] && rid_q[i] == cur_reg.txn_id)
                    begin
                        hit = 1'b1;
                    end
                end
                if (rb < cur_reg.batch)
                begin
                    meta_upd                  = 1'b1;
                    rid_upd                   = 1'b1;
                    meta_new                  = {cur_reg.batch, w_bit};
                    rid_new[WAW'(cur_reg.worker)] = cur_reg.txn_id;
                end
                else if (!hit)
                begin
                    meta_upd                  = 1'b1;
                    rid_upd                   = 1'b1;
                    meta_new                  = {rb, mask | w_bit};
                    rid_new[WAW'(cur_reg.worker)] = cur_reg.txn_id;
                end
            end
            OP_RAW:
            begin
                cf = (cur_reg.txn_id > wr_q.id) && (wr_q.batch == cur_reg.batch)
                     && (wr_q.id != '0) && !ab64[wr_q.worker];
            end
            OP_WAR:
            begin
                if (!(rb < cur_reg.batch))
                begin
                    for (int i = 0; i < WORKERS; i++)
                    begin
                        if (mask[i] && rid_q[i] < cur_reg.txn_id && !abort_reg[i])
                        begin
                            cf = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                cf = 1'b0;
            end
        endcase
        abort_next = abn64[WORKERS-1:0];
        ab_out     = (cur_reg.op == OP_BADW) ? 1'b0 : abn64[cur_reg.worker];
    end

    // Write port: the clearing pass shares it with execution.
    assign wa      = clearing ? clr_cnt_reg : KAW'(cur_reg.key);
    assign wr_we   = clearing || (fire && wr_upd);
    assign meta_we = clearing || (fire && meta_upd);
    assign rid_we  = fire && rid_upd;

    always_ff @(posedge clk)
    begin
        if (wr_we)
        begin
            wr_mem[wa] <= clearing ? '0 : wr_new;
        end
        if (meta_we)
        begin
            meta_mem[wa] <= clearing ? '0 : meta_new;
        end
        if (rid_we)
        begin
            rid_mem[wa] <= rid_new;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            wr_q   <= wr_mem[rd_addr];
            meta_q <= meta_mem[rd_addr];
            rid_q  <= rid_mem[rd_addr];
            cur_reg <= head.item;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == KAW'(KEYS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            abort_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (fire)
            begin
                abort_reg     <= abort_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            conflict_reg <= cf;
            aborted_reg  <= ab_out;
        end
    end

    assign out_valid      = out_valid_reg;
    assign conflict       = conflict_reg;
    assign worker_aborted = aborted_reg;

endmodule

// File: hdl/batch_reservation_conflict_check_core.sv
// Batch reservation conflict checker, top level.
// An input transfer is written into the queue, its key records are read into
// registers, then it executes into the result register, which can stall.
// The next item's key records are read only after the current item has executed.
// Reset: clears control and abort flags, then a clearing pass over all KEYS keys
// zeroes the writer records and reader batch/mask; in_stall is high during the pass.
module batch_reservation_conflict_check_core
    import brcc_pkg::*;
#(
    parameter int KEYS    = KEYS_DEF,
    parameter int WORKERS = WORKERS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [ACT_W-1:0] action,
    input  logic [KEY_W-1:0] key,
    input  logic [ID_W-1:0]  txn_id,
    input  logic [ID_W-1:0]  batch,
    input  logic [WID_W-1:0] worker,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             conflict,
    output logic             worker_aborted
);

    head_t head;
    logic  pop;
    logic  busy;

    // Front: classification and queue.
    brcc_front #(
        .KEYS    (KEYS),
        .WORKERS (WORKERS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .busy     (busy),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .key      (key),
        .txn_id   (txn_id),
        .batch    (batch),
        .worker   (worker),
        .head     (head),
        .pop      (pop)
    );

    // Back: record memories and result register.
    brcc_back #(
        .KEYS    (KEYS),
        .WORKERS (WORKERS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .busy           (busy),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .conflict       (conflict),
        .worker_aborted (worker_aborted)
    );

endmodule
